// ===== design/epmp_pkg.sv =====
`timescale 1ns / 1ps

package epmp_pkg;

   localparam int EaseDepth       = 1024;
   localparam int EaseIdxBits     = $clog2(EaseDepth);
   localparam int EaseWidth       = 16;
   localparam int EaseFullWidth   = EaseWidth + 1;
   localparam int ProgFracBits    = 16;
   localparam int ProgWidth       = ProgFracBits + 1;
   localparam int PosWidth        = 32;
   localparam int ProdWidth       = PosWidth + EaseFullWidth + 1;
   localparam int StepWidth       = 17;
   localparam int DwellWidth      = 16;
   localparam int DwellCntWidth   = 17;
   localparam int CsrIdxWidth     = 3;
   localparam int CsrDataWidth    = 32;
   localparam int Axes            = 3;

   localparam logic [ProgWidth-1:0]     ProgOne   = ProgWidth'(1) << ProgFracBits;
   localparam logic [EaseFullWidth-1:0] EaseOne   = EaseFullWidth'(1) << EaseWidth;
   localparam logic [StepWidth-1:0]     StepReset = StepWidth'(656);

   localparam logic [63:0] PiQ30      = 64'd3373259426;
   localparam logic [63:0] EaseRomDiv = 64'(2 * EaseDepth);
   localparam logic [63:0] EaseRomRnd = 64'(EaseDepth);

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_START_X       = 3'd0,
      CSR_START_Y       = 3'd1,
      CSR_START_Z       = 3'd2,
      CSR_GOAL_X        = 3'd3,
      CSR_GOAL_Y        = 3'd4,
      CSR_GOAL_Z        = 3'd5,
      CSR_PROGRESS_STEP = 3'd6,
      CSR_DWELL_TICKS   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      POS_HOLD  = 2'd0,
      POS_START = 2'd1,
      POS_BLEND = 2'd2
   } pos_op_type;

   typedef struct packed {
      pos_op_type op;
      logic       moving;
      logic       returning;
   } stage_ctl_type;

   // round(65536 * sin^2(x)), x in Q30 radians below pi/2, Taylor series
   function automatic logic [EaseWidth-1:0] sin_sq_q16(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] prod;
      logic [63:0] v;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 5; k++) begin
         prod = (term * x2) >> 30;
         case (k)
            1: term = prod / 64'd6;
            2: term = prod / 64'd20;
            3: term = prod / 64'd42;
            4: term = prod / 64'd72;
            default: term = prod / 64'd110;
         endcase
         if ((k % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      v = ($unsigned(sum) * $unsigned(sum) + (64'd1 << 43)) >> 44;
      if (v > 64'd65535) begin
         v = 64'd65535;
      end
      return v[EaseWidth-1:0];
   endfunction

   function automatic logic [EaseDepth*EaseWidth-1:0] ease_rom_image();
      logic [EaseDepth*EaseWidth-1:0] img;
      logic [63:0] x;
      img = '0;
      for (int i = 0; i < EaseDepth; i++) begin
         x = (PiQ30 * 64'(i) + EaseRomRnd) / EaseRomDiv;
         img[i*EaseWidth +: EaseWidth] = sin_sq_q16(x);
      end
      return img;
   endfunction

endpackage

// ===== design/epmp_ease_rom.sv =====
`timescale 1ns / 1ps

module epmp_ease_rom (
   input  logic                               clock,
   input  logic                               load,
   input  logic [epmp_pkg::EaseIdxBits-1:0]   rd_index,
   output logic [epmp_pkg::EaseWidth-1:0]     rd_data
);

   localparam logic [epmp_pkg::EaseDepth*epmp_pkg::EaseWidth-1:0] RomImage =
      epmp_pkg::ease_rom_image();

   logic [epmp_pkg::EaseWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         rd_data_ff <= RomImage[rd_index*epmp_pkg::EaseWidth +: epmp_pkg::EaseWidth];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/epmp_axis_blend.sv =====
`timescale 1ns / 1ps

module epmp_axis_blend (
   input  logic                                   clock,
   input  logic                                   load,
   input  logic signed [epmp_pkg::PosWidth-1:0]   start_pos,
   input  logic signed [epmp_pkg::PosWidth-1:0]   goal_pos,
   input  logic [epmp_pkg::EaseFullWidth-1:0]     ease,
   output logic signed [epmp_pkg::PosWidth-1:0]   blend_pos
);

   localparam int SumWidth = epmp_pkg::ProdWidth + 1;

   logic signed [epmp_pkg::ProdWidth-1:0] prod_start_ff;
   logic signed [epmp_pkg::ProdWidth-1:0] prod_goal_ff;
   logic [epmp_pkg::EaseFullWidth-1:0]    wt_start;
   logic signed [SumWidth-1:0]            sum;

   assign wt_start = epmp_pkg::EaseOne - ease;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_start_ff <= epmp_pkg::ProdWidth'(start_pos)
                        * epmp_pkg::ProdWidth'($signed({1'b0, wt_start}));
         prod_goal_ff  <= epmp_pkg::ProdWidth'(goal_pos)
                        * epmp_pkg::ProdWidth'($signed({1'b0, ease}));
      end
   end

   // floor((a*(1-e) + b*e + half) / 2^16)
   assign sum = SumWidth'(prod_start_ff) + SumWidth'(prod_goal_ff)
              + SumWidth'(32768);
   assign blend_pos = sum[epmp_pkg::PosWidth+15:16];

endmodule

// ===== design/eased_pingpong_motion_profile_core.sv =====
`timescale 1ns / 1ps

// Eased ping-pong motion profile.
// Each req_ transaction is one tick (pause, restart); each yields exactly one
// rsp_ transaction carrying the position after that tick and the moving and
// returning flags. Both channels are valid/ready.
// Pipeline: a result passes the ease ROM's registered read, the per-axis
// multiply registers, then the sum, rounding and result register.
// Throughput: one transaction per cycle when not stalled. Tick state (progress,
// dwell count, direction) updates at acceptance; position follows down the pipeline.
// Receiver stall: stages fill behind the result register and req_ready drops
// only when every stage holds a transaction; nothing is lost or repeated.
// Reset (synchronous, active high): registers take their reset values
// (step 656, all positions and dwell zero), the pipeline empties and the
// block is travelling towards the goal from progress zero.
// The csr_ port writes one register per cycle with csr_we; write it only
// while no transaction is in flight.

module eased_pingpong_motion_profile_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_pause,
   input  logic                                    req_restart,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [epmp_pkg::PosWidth-1:0]    rsp_pos_x,
   output logic signed [epmp_pkg::PosWidth-1:0]    rsp_pos_y,
   output logic signed [epmp_pkg::PosWidth-1:0]    rsp_pos_z,
   output logic                                    rsp_moving,
   output logic                                    rsp_returning,
   input  logic                                    csr_we,
   input  logic [epmp_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [epmp_pkg::CsrDataWidth-1:0]       csr_wdata
);

   logic signed [epmp_pkg::PosWidth-1:0]   start_ff [epmp_pkg::Axes];
   logic signed [epmp_pkg::PosWidth-1:0]   goal_ff  [epmp_pkg::Axes];
   logic [epmp_pkg::StepWidth-1:0]         step_ff;
   logic [epmp_pkg::DwellWidth-1:0]        dwell_ticks_ff;

   logic [epmp_pkg::ProgWidth-1:0]         progress_ff, progress_in;
   logic [epmp_pkg::DwellCntWidth-1:0]     dwell_cnt_ff, dwell_cnt_in;
   logic                                   travel_ff, travel_in;
   logic                                   back_ff, back_in;
   epmp_pkg::pos_op_type                   op_in;

   logic                                   s1_v_ff, s2_v_ff, out_v_ff;
   epmp_pkg::stage_ctl_type                s1_ctl_ff, s2_ctl_ff;
   logic                                   s1_full_ff;
   logic                                   out_moving_ff, out_returning_ff;
   logic signed [epmp_pkg::PosWidth-1:0]   pos_ff [epmp_pkg::Axes];

   logic                                   out_free, s2_free, s1_free, accept;
   logic [epmp_pkg::EaseIdxBits-1:0]       ease_idx;
   logic [epmp_pkg::ProgWidth+epmp_pkg::EaseIdxBits-1:0] idx_wide;
   logic [epmp_pkg::EaseWidth-1:0]         rom_data;
   logic [epmp_pkg::EaseFullWidth-1:0]     ease_s1;
   logic signed [epmp_pkg::PosWidth-1:0]   blend_pos [epmp_pkg::Axes];

   assign out_free  = !out_v_ff || rsp_ready;
   assign s2_free   = !s2_v_ff || out_free;
   assign s1_free   = !s1_v_ff || s2_free;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < epmp_pkg::Axes; a++) begin
            start_ff[a] <= '0;
            goal_ff[a]  <= '0;
         end
         step_ff        <= epmp_pkg::StepReset;
         dwell_ticks_ff <= '0;
      end else if (csr_we) begin
         case (epmp_pkg::csr_index_type'(csr_index))
            epmp_pkg::CSR_START_X:       start_ff[0]    <= $signed(csr_wdata);
            epmp_pkg::CSR_START_Y:       start_ff[1]    <= $signed(csr_wdata);
            epmp_pkg::CSR_START_Z:       start_ff[2]    <= $signed(csr_wdata);
            epmp_pkg::CSR_GOAL_X:        goal_ff[0]     <= $signed(csr_wdata);
            epmp_pkg::CSR_GOAL_Y:        goal_ff[1]     <= $signed(csr_wdata);
            epmp_pkg::CSR_GOAL_Z:        goal_ff[2]     <= $signed(csr_wdata);
            epmp_pkg::CSR_PROGRESS_STEP: step_ff <= csr_wdata[epmp_pkg::StepWidth-1:0];
            epmp_pkg::CSR_DWELL_TICKS:
               dwell_ticks_ff <= csr_wdata[epmp_pkg::DwellWidth-1:0];
            default: ;
         endcase
      end
   end

   // tick update
   always_comb begin
      logic [epmp_pkg::ProgWidth:0] fwd;
      progress_in  = progress_ff;
      dwell_cnt_in = dwell_cnt_ff;
      travel_in    = travel_ff;
      back_in      = back_ff;
      op_in        = epmp_pkg::POS_HOLD;
      fwd          = {1'b0, progress_ff} + (epmp_pkg::ProgWidth+1)'(step_ff);
      if (!req_pause) begin
         if (req_restart) begin
            progress_in  = '0;
            dwell_cnt_in = '0;
            travel_in    = 1'b0;
            back_in      = 1'b0;
            op_in        = epmp_pkg::POS_START;
         end else begin
            if (travel_ff) begin
               op_in = epmp_pkg::POS_BLEND;
               if (!back_ff) begin
                  if (fwd >= {1'b0, epmp_pkg::ProgOne}) begin
                     progress_in = epmp_pkg::ProgOne;
                     travel_in   = 1'b0;
                     back_in     = 1'b1;
                  end else begin
                     progress_in = fwd[epmp_pkg::ProgWidth-1:0];
                  end
               end else begin
                  if (step_ff >= progress_ff) begin
                     progress_in = '0;
                     travel_in   = 1'b0;
                     back_in     = 1'b0;
                  end else begin
                     progress_in = progress_ff - step_ff;
                  end
               end
            end
            if (!travel_in) begin
               dwell_cnt_in = dwell_cnt_ff + epmp_pkg::DwellCntWidth'(1);
            end
            if (dwell_cnt_in > epmp_pkg::DwellCntWidth'(dwell_ticks_ff)) begin
               travel_in    = 1'b1;
               dwell_cnt_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff  <= '0;
         dwell_cnt_ff <= '0;
         travel_ff    <= 1'b1;
         back_ff      <= 1'b0;
      end else if (accept) begin
         progress_ff  <= progress_in;
         dwell_cnt_ff <= dwell_cnt_in;
         travel_ff    <= travel_in;
         back_ff      <= back_in;
      end
   end

   // stage 1: ease lookup
   assign idx_wide = {progress_in, {epmp_pkg::EaseIdxBits{1'b0}}} >> epmp_pkg::ProgFracBits;
   assign ease_idx = idx_wide[epmp_pkg::EaseIdxBits-1:0];

   epmp_ease_rom u_ease_rom (
      .clock    (clock),
      .load     (accept),
      .rd_index (ease_idx),
      .rd_data  (rom_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_free) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff  <= '{op: op_in, moving: travel_in, returning: back_in};
         s1_full_ff <= progress_in >= epmp_pkg::ProgOne;
      end
   end

   assign ease_s1 = s1_full_ff ? epmp_pkg::EaseOne : {1'b0, rom_data};

   // stage 2: per-axis products
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_free) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_v_ff) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   for (genvar a = 0; a < epmp_pkg::Axes; a++) begin : g_axis
      epmp_axis_blend u_blend (
         .clock     (clock),
         .load      (s2_free && s1_v_ff),
         .start_pos (start_ff[a]),
         .goal_pos  (goal_ff[a]),
         .ease      (ease_s1),
         .blend_pos (blend_pos[a])
      );
   end

   // stage 3: result register, also the held position
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < epmp_pkg::Axes; a++) begin
            pos_ff[a] <= '0;
         end
         out_moving_ff    <= 1'b1;
         out_returning_ff <= 1'b0;
      end else if (out_free && s2_v_ff) begin
         for (int a = 0; a < epmp_pkg::Axes; a++) begin
            case (s2_ctl_ff.op)
               epmp_pkg::POS_START: pos_ff[a] <= start_ff[a];
               epmp_pkg::POS_BLEND: pos_ff[a] <= blend_pos[a];
               default:             pos_ff[a] <= pos_ff[a];
            endcase
         end
         out_moving_ff    <= s2_ctl_ff.moving;
         out_returning_ff <= s2_ctl_ff.returning;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_pos_x     = pos_ff[0];
   assign rsp_pos_y     = pos_ff[1];
   assign rsp_pos_z     = pos_ff[2];
   assign rsp_moving    = out_moving_ff;
   assign rsp_returning = out_returning_ff;

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !out_v_ff |-> req_ready)
      else $error("request refused with empty result stage");

   a_dwell_only_idle: assert property (@(posedge clock) disable iff (reset)
      dwell_cnt_ff != '0 |-> !travel_ff)
      else $error("dwell counting while travelling");

   a_rest_at_end: assert property (@(posedge clock) disable iff (reset)
      !travel_ff |-> (back_ff ? progress_ff == epmp_pkg::ProgOne : progress_ff == '0))
      else $error("resting away from an end");

   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      progress_ff <= epmp_pkg::ProgOne)
      else $error("progress beyond one");

   a_result_from_stage2: assert property (@(posedge clock) disable iff (reset)
      $rose(out_v_ff) |-> $past(s2_v_ff))
      else $error("result without a transaction behind it");

endmodule
